// ----- hdl/gtg_pkg.sv -----
// Shared types, constants and tables for the go-to-goal controller.
// Used by go_to_goal_heading_distance_controller_top; no dependencies.
package gtg_pkg;

  // Coordinate and angle formats
  localparam int COORD_WIDTH   = 32;  // Q16.16 positions
  localparam int CORDIC_STAGES = 16;  // vectoring iterations, 8 to 32
  localparam int ANGLE_W       = 16;  // binary angle, 2^15 = pi
  localparam int CZW           = 32;  // CORDIC internal angle, 2^31 = pi
  localparam int GAIN_W        = 16;  // Q8.8 gains
  localparam int OUT_W         = 32;

  // Datapath widths
  localparam int AW        = COORD_WIDTH;      // |dx|, |dy|
  localparam int XW        = COORD_WIDTH + 4;  // CORDIC x/y with gain headroom
  localparam int SQW       = 2 * AW;           // one square
  localparam int RADW      = 2 * AW + 2;       // sum of squares, even width
  localparam int RTW       = AW + 1;           // square root
  localparam int REMW      = RTW + 3;          // root remainder
  localparam int SQRT_ITER = RADW / 2;
  localparam int PRW       = RTW + GAIN_W;     // gain product
  localparam int PW        = PRW - 7;          // rounded product
  localparam int PXW       = (PW > OUT_W + 1) ? PW : OUT_W + 1;

  // Pipeline stage positions
  localparam int S_DIFF      = 0;
  localparam int S_ABS       = 1;
  localparam int S_SQ        = 2;
  localparam int S_SUM       = 3;
  localparam int S_SQRT0     = 4;
  localparam int S_SQRT_LAST = S_SQRT0 + SQRT_ITER - 1;
  localparam int S_MUL       = S_SQRT_LAST + 1;
  localparam int S_RND       = S_MUL + 1;
  localparam int S_FIN       = S_RND + 1;
  localparam int S_CORD0     = 2;
  localparam int S_ERR       = S_CORD0 + CORDIC_STAGES;
  localparam int S_MAG       = S_ERR + 1;

  // Register map
  localparam int APB_AW    = 5;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_GOAL_X     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GOAL_Y     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STOP_DIST  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ANGLE_DB   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LIN_GAIN   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ANG_GAIN   = 3'd5;

  localparam logic [30:0]         RST_STOP_DIST = 31'd655;
  localparam logic [14:0]         RST_ANGLE_DB  = 15'd834;
  localparam logic [GAIN_W-1:0]   RST_LIN_GAIN  = 16'd5120;
  localparam logic [GAIN_W-1:0]   RST_ANG_GAIN  = 16'd5120;

  localparam logic [CZW-1:0]   CZ_HALF  = 32'h8000_0000;
  localparam logic [CZW-1:0]   CZ_ROUND = 32'h0000_8000;
  localparam logic [OUT_W-1:0] SAT_POS  = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] SAT_NEG  = 32'h8000_0000;

  // atan(2^-i), 2^31 = pi
  localparam logic [CZW-1:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef enum logic [1:0] {
    MODE_ARRIVED = 2'd0,
    MODE_TURN    = 2'd1,
    MODE_DRIVE   = 2'd2
  } drive_mode_e;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [ANGLE_W-1:0]     heading;
  } in_item_t;

  typedef struct packed {
    logic [30:0]             linear_speed;
    logic signed [OUT_W-1:0] angular_speed;
    logic [1:0]              drive_mode;
  } out_item_t;

  // One pipeline slot; each stage fills in its own fields
  typedef struct packed {
    logic signed [ANGLE_W-1:0] heading;
    logic                      zero;
    logic signed [XW-1:0]      cx;
    logic signed [XW-1:0]      cy;
    logic [CZW-1:0]            cz;
    logic [AW-1:0]             ax;
    logic [AW-1:0]             ay;
    logic [SQW-1:0]            sqx;
    logic [SQW-1:0]            sqy;
    logic [RADW-1:0]           rad;
    logic [RTW-1:0]            root;
    logic [REMW-1:0]           rem;
    logic signed [ANGLE_W-1:0] err;
    logic [ANGLE_W-1:0]        mag;
    logic                      neg;
    logic                      turn;
    logic                      arrive;
    logic [PRW-1:0]            prod;
    logic [OUT_W-1:0]          pc;
    out_item_t                 res;
  } pipe_t;

endpackage

// ----- hdl/go_to_goal_heading_distance_controller_top.sv -----
// Go-to-goal heading/distance controller, top level.
// Depends on gtg_pkg for formats, stage map, register map and the atan table.

// One pose transaction in, one command transaction out, one pose per clock
// while not stalled. The pose runs down a 40-stage pipeline: goal offset,
// absolute values, two 32x32 squares and their sum, then a restoring square
// root that settles one root bit per stage (33 stages, the figure that sets
// latency). In parallel a CORDIC vectoring unit, one iteration per stage,
// yields the bearing, from which the wrapped heading error and its magnitude
// follow. A shared 33x16 multiplier applies the angular or linear gain, then
// rounding, saturation and mode selection. With the output side ready the
// block sustains one transaction per clock. A two-entry output stage (register
// plus skid) lets in_ready_o come straight from a flop, so a stalled consumer
// freezes the pipeline once the skid entry fills, without losing or repeating
// anything. Config registers are to be written over the APB-style port only
// while the block is idle; the block itself does not enforce this.

module go_to_goal_heading_distance_controller_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // pose channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  gtg_pkg::in_item_t           in_data_i,
  // command channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output gtg_pkg::out_item_t          out_data_o,
  // config port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gtg_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import gtg_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic signed [COORD_WIDTH-1:0] goal_x_q, goal_y_q;
  logic [30:0]                   stop_q;
  logic [14:0]                   dband_q;
  logic [GAIN_W-1:0]             lin_gain_q, ang_gain_q;
  logic                          cfg_wr;
  logic [REG_IDX_W-1:0]          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[APB_AW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q   <= '0;
      goal_y_q   <= '0;
      stop_q     <= RST_STOP_DIST;
      dband_q    <= RST_ANGLE_DB;
      lin_gain_q <= RST_LIN_GAIN;
      ang_gain_q <= RST_ANG_GAIN;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GOAL_X:    goal_x_q   <= pwdata[COORD_WIDTH-1:0];
        REG_GOAL_Y:    goal_y_q   <= pwdata[COORD_WIDTH-1:0];
        REG_STOP_DIST: stop_q     <= pwdata[30:0];
        REG_ANGLE_DB:  dband_q    <= pwdata[14:0];
        REG_LIN_GAIN:  lin_gain_q <= pwdata[GAIN_W-1:0];
        REG_ANG_GAIN:  ang_gain_q <= pwdata[GAIN_W-1:0];
        default: ;  // unmapped addresses ignored
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GOAL_X:    prdata = 32'(goal_x_q);
      REG_GOAL_Y:    prdata = 32'(goal_y_q);
      REG_STOP_DIST: prdata = {1'b0, stop_q};
      REG_ANGLE_DB:  prdata = {17'd0, dband_q};
      REG_LIN_GAIN:  prdata = {16'd0, lin_gain_q};
      REG_ANG_GAIN:  prdata = {16'd0, ang_gain_q};
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline. Every stage shifts together when en is high; en drops only
  // while the skid entry is occupied.
  // ---------------------------------------------------------------------
  pipe_t            stg_q [S_FIN+1];
  pipe_t            stg_d [S_FIN+1];
  logic [S_FIN:0]   vld_q;
  logic             en;

  assign in_ready_o = en;

  for (genvar k = 0; k <= S_FIN; k++) begin : g_stg
    if (k == S_DIFF) begin : g_first
      // goal offset, sign-extended for CORDIC headroom
      always_comb begin
        pipe_t                   s;
        logic [COORD_WIDTH:0]    dx, dy;
        s  = '0;
        dx = {goal_x_q[COORD_WIDTH-1], goal_x_q}
           - {in_data_i.pos_x[COORD_WIDTH-1], in_data_i.pos_x};
        dy = {goal_y_q[COORD_WIDTH-1], goal_y_q}
           - {in_data_i.pos_y[COORD_WIDTH-1], in_data_i.pos_y};
        s.heading = in_data_i.heading;
        s.cx      = {{(XW-COORD_WIDTH-1){dx[COORD_WIDTH]}}, dx};
        s.cy      = {{(XW-COORD_WIDTH-1){dy[COORD_WIDTH]}}, dy};
        stg_d[k]  = s;
      end
    end else begin : g_next
      localparam int CI = (k >= S_CORD0 && k < S_ERR) ? (k - S_CORD0) : 0;

      always_comb begin
        pipe_t                p, s;
        logic signed [XW-1:0] xs, ys;
        logic [CZW-1:0]       czr;
        logic [REMW-1:0]      tmp, trial;
        logic                 ge;
        logic [RTW-1:0]       ma;
        logic [GAIN_W-1:0]    mb;
        logic [PRW:0]         rnd;
        logic [PXW-1:0]       pr;
        logic                 sat;
        p     = stg_q[k-1];
        s     = p;
        xs    = p.cx >>> CI;
        ys    = p.cy >>> CI;
        czr   = p.cz + CZ_ROUND;
        tmp   = {p.rem[REMW-3:0], p.rad[RADW-1 -: 2]};
        trial = {1'b0, p.root, 2'b01};
        ge    = (tmp >= trial);
        ma    = p.turn ? RTW'(p.mag) : p.root;
        mb    = p.turn ? ang_gain_q : lin_gain_q;
        rnd   = {1'b0, p.prod} + (PRW+1)'(128);
        pr    = PXW'(rnd[PRW:8]);
        sat   = |pr[PXW-1:OUT_W-1];

        if (k == S_ABS) begin
          s.ax   = p.cx[XW-1] ? AW'(-p.cx) : AW'(p.cx);
          s.ay   = p.cy[XW-1] ? AW'(-p.cy) : AW'(p.cy);
          s.zero = (p.cx == '0) && (p.cy == '0);
          // fold the left half-plane onto the right
          if (p.cx[XW-1]) begin
            s.cx = -p.cx;
            s.cy = -p.cy;
            s.cz = CZ_HALF;
          end else begin
            s.cz = '0;
          end
        end

        if (k == S_SQ) begin
          s.sqx = SQW'(p.ax) * SQW'(p.ax);
          s.sqy = SQW'(p.ay) * SQW'(p.ay);
        end

        if (k == S_SUM) begin
          s.rad  = RADW'(p.sqx) + RADW'(p.sqy);
          s.root = '0;
          s.rem  = '0;
        end

        // CORDIC vectoring iteration CI
        if (k >= S_CORD0 && k < S_ERR) begin
          if (!p.cy[XW-1]) begin
            s.cx = p.cx + ys;
            s.cy = p.cy - xs;
            s.cz = p.cz + ATAN_TAB[CI];
          end else begin
            s.cx = p.cx - ys;
            s.cy = p.cy + xs;
            s.cz = p.cz - ATAN_TAB[CI];
          end
        end

        if (k == S_ERR) begin
          s.err = p.zero ? p.heading : p.heading - signed'(czr[CZW-1 -: ANGLE_W]);
        end

        if (k == S_MAG) begin
          s.neg  = p.err[ANGLE_W-1];
          s.mag  = p.err[ANGLE_W-1] ? ANGLE_W'(-p.err) : ANGLE_W'(p.err);
          s.turn = (s.mag > {1'b0, dband_q});
        end

        // restoring square root, one bit per stage
        if (k >= S_SQRT0 && k <= S_SQRT_LAST) begin
          s.rem  = ge ? tmp - trial : tmp;
          s.root = {p.root[RTW-2:0], ge};
          s.rad  = {p.rad[RADW-3:0], 2'b00};
        end

        if (k == S_MUL) begin
          s.arrive = ({31'd0, p.root} < {{RTW{1'b0}}, stop_q});
          s.prod   = PRW'(ma) * PRW'(mb);
        end

        if (k == S_RND) begin
          if (p.turn) begin
            s.pc = sat ? (p.neg ? SAT_NEG : SAT_POS) : pr[OUT_W-1:0];
          end else begin
            s.pc = sat ? SAT_POS : pr[OUT_W-1:0];
          end
        end

        if (k == S_FIN) begin
          if (p.arrive) begin
            s.res.drive_mode    = MODE_ARRIVED;
            s.res.linear_speed  = '0;
            s.res.angular_speed = '0;
          end else if (p.turn) begin
            s.res.drive_mode    = MODE_TURN;
            s.res.linear_speed  = '0;
            s.res.angular_speed = p.neg ? signed'(-p.pc) : signed'(p.pc);
          end else begin
            s.res.drive_mode    = MODE_DRIVE;
            s.res.linear_speed  = p.pc[30:0];
            s.res.angular_speed = '0;
          end
        end

        stg_d[k] = s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[S_FIN-1:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------------
  // Output register plus skid entry
  // ---------------------------------------------------------------------
  out_item_t out_q, skid_q;
  logic      out_vld_q, skid_vld_q;
  logic      tail_v, load_out, load_skid, pop_skid;

  assign en        = !skid_vld_q;
  assign tail_v    = vld_q[S_FIN];
  assign load_out  = en && tail_v && (!out_vld_q || out_ready_i);
  assign load_skid = en && tail_v && out_vld_q && !out_ready_i;
  assign pop_skid  = !en && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (load_out || pop_skid) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (load_skid) begin
        skid_vld_q <= 1'b1;
      end else if (pop_skid) begin
        skid_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= stg_q[S_FIN].res;
    end else if (pop_skid) begin
      out_q <= skid_q;
    end
    if (load_skid) begin
      skid_q <= stg_q[S_FIN].res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_skid_implies_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held while output register empty");

  a_stall_to_skid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && tail_v && out_vld_q && !out_ready_i) |=> skid_vld_q)
    else $error("finished transaction not parked in skid entry");

  a_mode_speeds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |->
      ((out_q.drive_mode == MODE_ARRIVED && out_q.linear_speed == '0
         && out_q.angular_speed == '0)
       || (out_q.drive_mode == MODE_TURN && out_q.linear_speed == '0)
       || (out_q.drive_mode == MODE_DRIVE && out_q.angular_speed == '0)))
    else $error("speed fields inconsistent with drive mode");

endmodule
